/* sv/vpcv_pkg.sv */
// Package for the vertex projection, clip and viewport pipeline.
// Holds shared widths, register indexes and reset values; no dependencies.
`default_nettype none
package vpcv_pkg;
  localparam int COORD_W = 32;
  localparam int REG_W = 64;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = 3;
  localparam int CLIP_W = 50;
  localparam int FRAC_W = 17;
  localparam int SX_W = 27;
  localparam int SY_W = 26;
  localparam int DIM_W = 14;
  localparam int DEF_SCREEN_WIDTH = 1280;
  localparam int DEF_SCREEN_HEIGHT = 720;
  localparam logic [REG_W-1:0] RST_R0_LO = 64'd65536;
  localparam logic [REG_W-1:0] RST_R1_LO = 64'd281474976710656;
  localparam logic [REG_W-1:0] RST_R2_HI = 64'd65536;
  localparam logic [REG_W-1:0] RST_R3_HI = 64'd281474976710656;
  localparam logic [IDX_W-1:0] REG_R0_LO = 3'd0;
  localparam logic [IDX_W-1:0] REG_R0_HI = 3'd1;
  localparam logic [IDX_W-1:0] REG_R1_LO = 3'd2;
  localparam logic [IDX_W-1:0] REG_R1_HI = 3'd3;
  localparam logic [IDX_W-1:0] REG_R2_LO = 3'd4;
  localparam logic [IDX_W-1:0] REG_R2_HI = 3'd5;
  localparam logic [IDX_W-1:0] REG_R3_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_R3_HI = 3'd7;
endpackage
`default_nettype wire

/* sv/vertex_project_clip_viewport_top.sv */
// Vertex transform, clip test, perspective divide and viewport map.
// Depends on vpcv_pkg.
//
// Channel | Dir | Signals                      | Contents
// s_axis  | in  | s_axis_tvalid/tready/tdata   | world_x, world_y, world_z (96 bits)
// m_axis  | out | m_axis_tvalid/tready/tdata   | visible, screen_x, screen_y (56 bits)
// cfg     | in  | cfg_we, cfg_index, cfg_data  | matrix register writes
//
// One point enters per cycle unless the output stalls. The pipeline holds one product
// stage, one sum stage, one clip test stage, 17 quotient-bit stages of the divider,
// one sign stage, one viewport multiply stage and one output stage.
// Reset is synchronous; it clears the valid bits and loads the identity matrix.
// Every stage advances together when the output register is free or empty, so a
// stall holds all requests in place and none is lost or repeated.
`default_nettype none
module vertex_project_clip_viewport_top #(
  parameter int SCREEN_WIDTH  = vpcv_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = vpcv_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // world_x [31:0], world_y [63:32], world_z [95:64]
  input  wire logic [95:0]                s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // visible [0], screen_x [27:1], screen_y [53:28], zero [55:54]
  output logic [55:0]                     m_axis_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [vpcv_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [vpcv_pkg::REG_W-1:0] cfg_data
);
  import vpcv_pkg::*;

  localparam int NDIV = FRAC_W;
  localparam logic [DIM_W-1:0] SW = DIM_W'(SCREEN_WIDTH);
  localparam logic [DIM_W-1:0] SH = DIM_W'(SCREEN_HEIGHT);
  localparam logic signed [CLIP_W-1:0] ONE = CLIP_W'(65536);

  logic [REG_W-1:0] mat [NUM_REGS];
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[REG_R0_LO] <= RST_R0_LO; mat[REG_R0_HI] <= '0;
      mat[REG_R1_LO] <= RST_R1_LO; mat[REG_R1_HI] <= '0;
      mat[REG_R2_LO] <= '0;        mat[REG_R2_HI] <= RST_R2_HI;
      mat[REG_R3_LO] <= '0;        mat[REG_R3_HI] <= RST_R3_HI;
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  function automatic logic signed [31:0] ent(input logic [REG_W-1:0] a [NUM_REGS],
                                             input int r, input int c);
    logic [REG_W-1:0] rg;
    rg = a[IDX_W'(r*2 + c/2)];
    return (c % 2 == 1) ? signed'(rg[63:32]) : signed'(rg[31:0]);
  endfunction

  // Global advance: the whole pipe moves when the output slot can take data.
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: twelve products floored to Q32.16.
  logic v1;
  logic signed [47:0] p1 [3][4];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          p1[r][c] <= 48'((64'(signed'(s_axis_tdata[r*32 +: 32])) *
                           64'(ent(mat, r, c))) >>> 16);
        end
      end
    end
  end

  // Stage 2: clip sums.
  logic v2;
  logic signed [CLIP_W-1:0] clip [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        clip[c] <= CLIP_W'(ent(mat, 3, c)) + CLIP_W'(p1[0][c]) +
                   CLIP_W'(p1[1][c]) + CLIP_W'(p1[2][c]);
      end
    end
  end

  // Stage 3: visibility, magnitudes and signs for the divider.
  function automatic logic [CLIP_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
    return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
  endfunction

  logic [CLIP_W-1:0] ax, ay, az, aw;
  logic vis_c;
  always_comb begin
    ax = mag(clip[0]); ay = mag(clip[1]); az = mag(clip[2]); aw = mag(clip[3]);
    if (clip[3] != '0) begin
      vis_c = ax <= aw && ay <= aw &&
              (clip[2] == '0 || (clip[2][CLIP_W-1] == clip[3][CLIP_W-1] && az <= aw));
    end else begin
      vis_c = clip[0] >= -ONE && clip[0] <= ONE && clip[1] >= -ONE &&
              clip[1] <= ONE && clip[2] >= 0 && clip[2] <= ONE;
    end
  end

  typedef struct packed {
    logic                    vld;
    logic                    vis;
    logic                    wz;     // w was zero: pass clip values through
    logic                    negx;
    logic                    negy;
    logic [CLIP_W-1:0]       d;
    logic [CLIP_W:0]         rx;
    logic [CLIP_W:0]         ry;
    logic [FRAC_W-1:0]       qx;
    logic [FRAC_W-1:0]       qy;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
  } div_t;

  div_t ds [NDIV+1];
  always_ff @(posedge clk) begin
    if (rst) ds[0].vld <= 1'b0;
    else if (adv) ds[0].vld <= v2;
    if (adv) begin
      ds[0].vis  <= vis_c;
      ds[0].wz   <= clip[3] == '0;
      ds[0].negx <= clip[0][CLIP_W-1] != clip[3][CLIP_W-1];
      ds[0].negy <= clip[1][CLIP_W-1] != clip[3][CLIP_W-1];
      ds[0].d    <= aw;
      ds[0].rx   <= {1'b0, ax};
      ds[0].ry   <= {1'b0, ay};
      ds[0].qx   <= '0;
      ds[0].qy   <= '0;
      ds[0].cx   <= clip[0];
      ds[0].cy   <= clip[1];
    end
  end

  // Restoring divider, one quotient bit per stage for x and y.
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    div_t nx;
    always_comb begin
      nx = ds[i];
      if (ds[i].rx >= {1'b0, ds[i].d}) begin
        nx.rx = ds[i].rx - {1'b0, ds[i].d};
        nx.qx = {ds[i].qx[FRAC_W-2:0], 1'b1};
      end else begin
        nx.qx = {ds[i].qx[FRAC_W-2:0], 1'b0};
      end
      if (ds[i].ry >= {1'b0, ds[i].d}) begin
        nx.ry = ds[i].ry - {1'b0, ds[i].d};
        nx.qy = {ds[i].qy[FRAC_W-2:0], 1'b1};
      end else begin
        nx.qy = {ds[i].qy[FRAC_W-2:0], 1'b0};
      end
      nx.rx = {nx.rx[CLIP_W-1:0], 1'b0};
      nx.ry = {nx.ry[CLIP_W-1:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (rst) ds[i+1].vld <= 1'b0;
      else if (adv) ds[i+1].vld <= ds[i].vld;
      if (adv) begin
        ds[i+1].vis <= nx.vis; ds[i+1].wz <= nx.wz;
        ds[i+1].negx <= nx.negx; ds[i+1].negy <= nx.negy;
        ds[i+1].d <= nx.d; ds[i+1].rx <= nx.rx; ds[i+1].ry <= nx.ry;
        ds[i+1].qx <= nx.qx; ds[i+1].qy <= nx.qy;
        ds[i+1].cx <= nx.cx; ds[i+1].cy <= nx.cy;
      end
    end
  end

  // Sign stage: form viewport operands (ndc_x + 1) and (1 - ndc_y), in [0, 2] if visible.
  logic v4, vis4;
  logic [FRAC_W:0] ox, oy;
  logic signed [CLIP_W-1:0] nxs, nys;
  always_comb begin
    div_t f;
    f = ds[NDIV];
    if (f.wz) begin
      nxs = f.cx; nys = f.cy;
    end else begin
      nxs = f.negx ? -CLIP_W'(f.qx) : CLIP_W'(f.qx);
      nys = f.negy ? -CLIP_W'(f.qy) : CLIP_W'(f.qy);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= ds[NDIV].vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vis4 <= ds[NDIV].vis;
      ox   <= (FRAC_W+1)'(nxs + ONE);
      oy   <= (FRAC_W+1)'(ONE - nys);
    end
  end

  // Viewport multiply.
  logic v5, vis5;
  logic [FRAC_W+DIM_W:0] mx, my;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vis5 <= vis4;
      mx   <= (FRAC_W+DIM_W+1)'(ox) * (FRAC_W+DIM_W+1)'(SW);
      my   <= (FRAC_W+DIM_W+1)'(oy) * (FRAC_W+DIM_W+1)'(SH);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v5;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata[55:54] <= 2'b00;
      m_axis_tdata[0]     <= vis5;
      m_axis_tdata[27:1]  <= vis5 ? SX_W'(mx >> 1) : '0;
      m_axis_tdata[53:28] <= vis5 ? SY_W'(my >> 1) : '0;
    end
  end
endmodule
`default_nettype wire

/* sv/vpcv_checker.sv */
// Port-level checker for the vertex pipeline, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module vpcv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed during stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[53:1] == '0)
    else $error("invisible point with nonzero coordinates");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00)
    else $error("padding bits set");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

bind vertex_project_clip_viewport_top vpcv_checker u_vpcv_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
